FILE: rtl/core/priority_schedule_wait_times_core_macros.svh
// ----------------------------------------------------------------------------
// Priority schedule core assertion macros
// Short forms for clocked, reset-gated concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_CORE_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define PSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/psw_pkg.sv
// ----------------------------------------------------------------------------
// Priority schedule package
// Shared widths, slot and result word layouts, and sequencer states.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int MAX_PROCS   = 64;
    localparam int SLOT_W      = $clog2(MAX_PROCS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int ID_W        = 7;
    localparam int TIME_W      = 22;
    localparam int TOTAL_W     = 28;
    localparam int AVG_W       = 30;
    localparam int FRAC_W      = 8;
    localparam int DIVIDEND_W  = TOTAL_W + FRAC_W;
    localparam int DIV_STEP_W  = $clog2(DIVIDEND_W);
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 136;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [SLOT_W-1:0]  id;
    } slot_t;

    // Result word, lowest field last.
    typedef struct packed {
        logic               pad;
        logic [AVG_W-1:0]   avg_turn_q8;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  wait_time;
        logic [PRIO_W-1:0]  job_prio;
        logic [BURST_W-1:0] job_burst;
        logic [ID_W-1:0]    job_id;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_SUM,
        ST_DIVW_GO,
        ST_DIVW_RUN,
        ST_DIVT_GO,
        ST_DIVT_RUN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

FILE: rtl/core/psw_store.sv
// ----------------------------------------------------------------------------
// Priority schedule job store
// Single-port-write, registered-read memory of job slots.
// ----------------------------------------------------------------------------
module psw_store
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [psw_pkg::SLOT_W-1:0] wr_addr,
    input  psw_pkg::slot_t             wr_data,
    input  logic [psw_pkg::SLOT_W-1:0] rd_addr,
    output psw_pkg::slot_t             rd_data
);
    import psw_pkg::*;

    slot_t mem_reg [MAX_PROCS];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/psw_div.sv
// ----------------------------------------------------------------------------
// Priority schedule divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psw_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [psw_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [psw_pkg::CNT_W-1:0]      divisor,
    output logic                           done,
    output logic [psw_pkg::DIVIDEND_W-1:0] quotient
);
    import psw_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      dvs_reg, dvs_next;
    logic [CNT_W:0]        shifted;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? CNT_W'(shifted - {1'b0, dvs_reg}) : shifted[CNT_W-1:0];
            step_next = step_reg - DIV_STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/priority_schedule_wait_times_core.sv
// Insertion: each job shifts up the stored jobs with a higher priority value (one per cycle)
//   and goes into the freed slot; a job that does not close the set returns to idle.
// The job that closes a set adds a summing pass, the two averages in turn on the shared
//   36-bit restoring divider, then one word per job, read once the output slot is free.
// Throughput: one job at a time; s_axis_tready is high only while the sequencer idles.
// Reset: rst_n clears the sequencer, job count and output valid; the store needs no clear.
// ----------------------------------------------------------------------------
// Priority schedule wait times core
// Non-preemptive priority scheduler: insertion-sorted job store, summing
// pass, shared divider for the averages, then schedule-order output.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side: jobs in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: burst_time[15:0], prio[23:16]
    input  logic [psw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tlast: last_job
    input  logic                            s_axis_tlast,
    // master side: scheduled jobs out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: job_id[6:0], job_burst[22:7], job_prio[30:23], wait_time[52:31],
    //        turnaround[74:53], avg_wait_q8[104:75], avg_turn_q8[134:105], zero[135]
    output logic [psw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tlast: last_result
    output logic                            m_axis_tlast
);
    import psw_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  vld_reg, vld_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  out_last_reg, out_last_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    slot_t                 new_reg, new_next;
    logic                  last_reg, last_next;
    logic [TIME_W-1:0]     acc_reg, acc_next;
    logic [TOTAL_W-1:0]    wait_tot_reg, wait_tot_next;
    logic [TOTAL_W-1:0]    turn_tot_reg, turn_tot_next;
    logic [AVG_W-1:0]      avg_w_reg, avg_w_next;
    logic [AVG_W-1:0]      avg_t_reg, avg_t_next;
    out_word_t             out_reg, out_next;

    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    slot_t                 wr_data;
    logic [SLOT_W-1:0]     rd_addr;
    slot_t                 rd_data;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;

    logic                  in_hs;
    logic                  slot_free;
    logic                  shift_up;
    logic                  sched;
    logic                  emit_last;
    logic [CNT_W-1:0]      cnt_dec;
    logic [TIME_W-1:0]     acc_plus;

    assign in_hs     = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_vld_reg || m_axis_tready;
    // stored entry moves up while its value is strictly higher: ties keep arrival order
    assign shift_up  = (rd_data.prio > new_reg.prio);
    // a full store starts the schedule as if the last mark were set
    assign sched     = last_reg || (count_reg == CNT_W'(MAX_PROCS - 1));
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign emit_last = (idx_reg == cnt_dec);
    assign acc_plus  = acc_reg + TIME_W'(rd_data.burst);

    psw_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    psw_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_hs)
                begin
                    state_next = (count_reg == '0) ? ST_PUT : ST_INS;
                end
            end
            ST_INS:
            begin
                if (shift_up)
                begin
                    state_next = (pos_reg == SLOT_W'(1)) ? ST_PUT : ST_INS;
                end
                else
                begin
                    state_next = sched ? ST_SUM : ST_IDLE;
                end
            end
            ST_PUT:
            begin
                state_next = sched ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if ((idx_reg == count_reg) && !vld_reg)
                begin
                    state_next = ST_DIVW_GO;
                end
            end
            ST_DIVW_GO:
            begin
                state_next = ST_DIVW_RUN;
            end
            ST_DIVW_RUN:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVT_GO;
                end
            end
            ST_DIVT_GO:
            begin
                state_next = ST_DIVT_RUN;
            end
            ST_DIVT_RUN:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                if (slot_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        vld_next      = vld_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        out_last_next = out_last_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        wait_tot_next = wait_tot_reg;
        turn_tot_next = turn_tot_reg;
        avg_w_next    = avg_w_reg;
        avg_t_next    = avg_t_reg;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = new_reg;
        rd_addr       = idx_reg[SLOT_W-1:0];
        div_start     = 1'b0;
        div_dividend  = {wait_tot_reg, FRAC_W'(0)};

        case (state_reg)
            ST_IDLE:
            begin
                // fetch the top stored entry for the first compare
                rd_addr = cnt_dec[SLOT_W-1:0];
                if (in_hs)
                begin
                    new_next.burst = s_axis_tdata[BURST_W-1:0];
                    new_next.prio  = s_axis_tdata[BURST_W +: PRIO_W];
                    new_next.id    = count_reg[SLOT_W-1:0];
                    last_next      = s_axis_tlast;
                    pos_next       = count_reg[SLOT_W-1:0];
                end
            end
            ST_INS:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    // move the entry one slot up, fetch the next one down
                    wr_data  = rd_data;
                    pos_next = pos_reg - SLOT_W'(1);
                    rd_addr  = pos_reg - SLOT_W'(2);
                end
                else
                begin
                    count_next    = count_reg + CNT_W'(1);
                    idx_next      = '0;
                    vld_next      = 1'b0;
                    acc_next      = '0;
                    wait_tot_next = '0;
                    turn_tot_next = '0;
                end
            end
            ST_PUT:
            begin
                wr_en         = 1'b1;
                count_next    = count_reg + CNT_W'(1);
                idx_next      = '0;
                vld_next      = 1'b0;
                acc_next      = '0;
                wait_tot_next = '0;
                turn_tot_next = '0;
            end
            ST_SUM:
            begin
                if (idx_reg != count_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    vld_next = 1'b1;
                end
                else
                begin
                    vld_next = 1'b0;
                end
                if (vld_reg)
                begin
                    wait_tot_next = wait_tot_reg + TOTAL_W'(acc_reg);
                    turn_tot_next = turn_tot_reg + TOTAL_W'(acc_plus);
                    acc_next      = acc_plus;
                end
            end
            ST_DIVW_GO:
            begin
                div_start = 1'b1;
                idx_next  = '0;
                acc_next  = '0;
            end
            ST_DIVW_RUN:
            begin
                if (div_done)
                begin
                    avg_w_next = div_quotient[AVG_W-1:0];
                end
            end
            ST_DIVT_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {turn_tot_reg, FRAC_W'(0)};
            end
            ST_DIVT_RUN:
            begin
                if (div_done)
                begin
                    avg_t_next = div_quotient[AVG_W-1:0];
                end
            end
            ST_EMIT_RD:
            begin
                rd_addr = idx_reg[SLOT_W-1:0];
            end
            ST_EMIT_LD:
            begin
                out_next.pad         = 1'b0;
                out_next.job_id      = ID_W'(rd_data.id) + ID_W'(1);
                out_next.job_burst   = rd_data.burst;
                out_next.job_prio    = rd_data.prio;
                out_next.wait_time   = acc_reg;
                out_next.turnaround  = acc_plus;
                out_next.avg_wait_q8 = avg_w_reg;
                out_next.avg_turn_q8 = avg_t_reg;
                out_last_next        = emit_last;
                out_vld_next         = 1'b1;
                acc_next             = acc_plus;
                idx_next             = idx_reg + CNT_W'(1);
                if (emit_last)
                begin
                    // set done: next job opens a new set with arrival number 1
                    count_next = '0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            vld_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_last_reg <= out_last_next;
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        wait_tot_reg <= wait_tot_next;
        turn_tot_reg <= turn_tot_next;
        avg_w_reg    <= avg_w_next;
        avg_t_reg    <= avg_t_next;
        out_reg      <= out_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/core/psw_chk.sv
// ----------------------------------------------------------------------------
// Priority schedule port checker
// Watches the stream ports of the core over time.
// ----------------------------------------------------------------------------
`include "priority_schedule_wait_times_core_macros.svh"

module psw_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [psw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [psw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import psw_pkg::*;

    logic in_word;

    assign in_word = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || !s_axis_tlast
                     || s_axis_tlast);

    // hold a stalled result word
    `PSW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result word changed")

    // one job at a time: drop ready after taking a word
    `PSW_ASSERT_NEXT(a_busy_after_word, in_word, !s_axis_tready, "ready stayed high after a job word")

    // turnaround is wait plus burst
    `PSW_ASSERT_NOW(a_turn_sum, m_axis_tvalid, m_axis_tdata[74:53] == 22'(m_axis_tdata[52:31] + m_axis_tdata[22:7]), "turnaround differs from wait plus burst")

    // job numbers run from one to the store depth
    `PSW_ASSERT_NOW(a_job_id_range, m_axis_tvalid, m_axis_tdata[6:0] != 7'd0 && m_axis_tdata[6:0] <= 7'(MAX_PROCS), "job id out of range")

endmodule

bind priority_schedule_wait_times_core psw_chk u_psw_chk (.*);

FILE: bench/priority_schedule_wait_times_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority schedule checker
// Watches both stream channels, rebuilds the schedule of every job set from
// the accepted job words, and compares each result word field by field.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_check
    import psw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // tdata: burst_time[15:0], prio[23:16]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: job_id, job_burst, job_prio, wait_time, turnaround, avg_wait_q8,
    //        avg_turn_q8, zero
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     mismatches,
    output int                     pending
);

    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] job_burst;
        logic [PRIO_W-1:0]  job_prio;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turn_q8;
        logic               last_result;
    } sched_word_t;

    // priority-ordered copy of the job store
    logic [BURST_W-1:0] held_burst [MAX_PROCS];
    logic [PRIO_W-1:0]  held_prio  [MAX_PROCS];
    logic [SLOT_W-1:0]  held_id    [MAX_PROCS];
    int                 held_count;

    sched_word_t        sched_queue [$];
    int                 fail_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Place a job after every held job of equal or lower priority value.
    task automatic file_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio);
        int pos;
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] > prio) begin
            held_burst[pos] = held_burst[pos-1];
            held_prio[pos]  = held_prio[pos-1];
            held_id[pos]    = held_id[pos-1];
            pos--;
        end
        held_burst[pos] = burst;
        held_prio[pos]  = prio;
        held_id[pos]    = SLOT_W'(held_count);
        held_count++;
    endtask

    // Sum the set, work out both averages, and queue one word per job.
    task automatic release_schedule();
        logic [TOTAL_W-1:0]    wait_sum;
        logic [TOTAL_W-1:0]    turn_sum;
        logic [31:0]           run;
        logic [DIVIDEND_W-1:0] avg_wait;
        logic [DIVIDEND_W-1:0] avg_turn;
        sched_word_t           word;
        wait_sum = '0;
        turn_sum = '0;
        run = '0;
        for (int k = 0; k < held_count; k++) begin
            wait_sum += run[TOTAL_W-1:0];
            run += held_burst[k];
            turn_sum += run[TOTAL_W-1:0];
        end
        avg_wait = {wait_sum, {FRAC_W{1'b0}}} / DIVIDEND_W'(held_count);
        avg_turn = {turn_sum, {FRAC_W{1'b0}}} / DIVIDEND_W'(held_count);
        run = '0;
        for (int k = 0; k < held_count; k++) begin
            word.job_id      = {1'b0, held_id[k]} + ID_W'(1);
            word.job_burst   = held_burst[k];
            word.job_prio    = held_prio[k];
            word.wait_time   = run[TIME_W-1:0];
            run += held_burst[k];
            word.turnaround  = run[TIME_W-1:0];
            word.avg_wait_q8 = avg_wait[AVG_W-1:0];
            word.avg_turn_q8 = avg_turn[AVG_W-1:0];
            word.last_result = (k == held_count - 1);
            sched_queue.push_back(word);
        end
        held_count = 0;
    endtask

    task automatic check_word(input logic [OUT_TDATA_W-1:0] data, input logic last);
        out_word_t   got;
        sched_word_t want;
        got = out_word_t'(data);
        if (sched_queue.size() == 0) begin
            report_mismatch("result word with no job pending", 64'(got.job_id), 64'(0));
        end
        else begin
            want = sched_queue.pop_front();
            if (got.job_id != want.job_id)
                report_mismatch("job_id", 64'(got.job_id), 64'(want.job_id));
            if (got.job_burst != want.job_burst)
                report_mismatch("job_burst", 64'(got.job_burst), 64'(want.job_burst));
            if (got.job_prio != want.job_prio)
                report_mismatch("job_prio", 64'(got.job_prio), 64'(want.job_prio));
            if (got.wait_time != want.wait_time)
                report_mismatch("wait_time", 64'(got.wait_time), 64'(want.wait_time));
            if (got.turnaround != want.turnaround)
                report_mismatch("turnaround", 64'(got.turnaround), 64'(want.turnaround));
            if (got.avg_wait_q8 != want.avg_wait_q8)
                report_mismatch("avg_wait_q8", 64'(got.avg_wait_q8), 64'(want.avg_wait_q8));
            if (got.avg_turn_q8 != want.avg_turn_q8)
                report_mismatch("avg_turn_q8", 64'(got.avg_turn_q8), 64'(want.avg_turn_q8));
            if (last !== want.last_result)
                report_mismatch("last_result", 64'(last), 64'(want.last_result));
            if (got.pad !== 1'b0)
                report_mismatch("pad bit", 64'(got.pad), 64'(0));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_count = 0;
            sched_queue.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                file_job(s_axis_tdata[BURST_W-1:0], s_axis_tdata[BURST_W +: PRIO_W]);
                // a full store closes the set even without the last mark
                if (s_axis_tlast || held_count == MAX_PROCS)
                    release_schedule();
            end
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata, m_axis_tlast);
            pending    <= sched_queue.size();
            mismatches <= fail_count;
        end
    end

endmodule

FILE: bench/priority_schedule_wait_times_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority schedule core test
// Feeds job sets of many sizes and priority shapes into the scheduler under
// random idling on both channels, with a checker that predicts every result.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core_test;

    import psw_pkg::*;

    localparam int RANDOM_JOBS     = 250;
    // Cycles with no word moving on either channel before the run is abandoned.
    // The slowest legal quiet stretch is a hold-off plus the summing and dividing
    // pass of a full set plus a 64-deep insertion shift.
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Drain pause after the last expected word, so that stray words can show.
    localparam int SETTLE_CYCLES   = 300;

    // priority shapes for a job set
    localparam int PRIO_ANY     = 0;
    localparam int PRIO_FEW     = 1;
    localparam int PRIO_FALLING = 2;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_SHUT   = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: burst_time[15:0], prio[23:16]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tlast: last_job
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: job_id[6:0], job_burst[22:7], job_prio[30:23], wait_time[52:31],
    //        turnaround[74:53], avg_wait_q8[104:75], avg_turn_q8[134:105], zero[135]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tlast: last_result
    logic                   m_axis_tlast;

    int mismatches;
    int pending;

    // sender burst bookkeeping and job tally
    int burst_left = 0;
    int jobs_sent  = 0;

    priority_schedule_wait_times_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    priority_schedule_wait_times_check u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold reset low once, at the start of the run, then release it.
    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offer one job word and hold it until the core takes it. Between bursts
    // drop tvalid for a random gap; inside a burst keep tvalid high so that
    // the next word follows back to back.
    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, burst};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        jobs_sent++;
    endtask

    // Mix the extremes in with fully random burst lengths.
    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BURST_W'($urandom);
        endcase
    endfunction

    // Send one set of jobs. A falling shape forces the longest insertion
    // shifts; a narrow shape makes many ties whose arrival order must hold.
    task automatic send_set(input int jobs, input int shape, input bit mark_end);
        logic [PRIO_W-1:0] prio;
        for (int i = 0; i < jobs; i++) begin
            case (shape)
                PRIO_FEW:     prio = PRIO_W'($urandom_range(0, 3));
                PRIO_FALLING: prio = PRIO_W'(255 - 3 * i - $urandom_range(0, 2));
                default:      prio = PRIO_W'($urandom);
            endcase
            send_job(pick_burst(), prio, mark_end && (i == jobs - 1));
        end
    endtask

    // Stimulus: directed sets first, then random sets, then drain and judge.
    initial
    begin : stimulus
        int  random_base;
        int  jobs;
        int  shape;
        bit  full_auto_done;
        bit  full_marked_done;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        full_auto_done   = 1'b0;
        full_marked_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // single-job sets at both extremes of every field
        send_job(16'hFFFF, 8'hFF, 1'b1);
        send_job(16'h0000, 8'h00, 1'b1);
        // falling priorities: every arrival shifts the whole store
        send_job(16'd300,  8'd200, 1'b0);
        send_job(16'd40,   8'd100, 1'b0);
        send_job(16'd7,    8'd50,  1'b0);
        send_job(16'hFFFF, 8'd0,   1'b1);
        // equal priorities: schedule must keep arrival order
        send_job(16'd1, 8'd7, 1'b0);
        send_job(16'd2, 8'd7, 1'b0);
        send_job(16'd3, 8'd7, 1'b0);
        send_job(16'd4, 8'd7, 1'b1);
        // mixed extremes, averages with a fraction part
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'hFFFF, 8'h00, 1'b0);
        send_job(16'd1,    8'h80, 1'b0);
        send_job(16'hFFFF, 8'hFF, 1'b0);
        send_job(16'h0000, 8'h00, 1'b1);
        // alternating bit patterns
        send_job(16'hAAAA, 8'h55, 1'b0);
        send_job(16'h5555, 8'hAA, 1'b0);
        send_job(16'h8001, 8'h55, 1'b1);

        random_base = jobs_sent;
        while (jobs_sent - random_base < RANDOM_JOBS) begin
            shape = $urandom_range(0, 2);
            if (!full_auto_done && jobs_sent - random_base >= 30) begin
                // fill the store with no last mark: the 64th job closes the set
                send_set(MAX_PROCS, shape, 1'b0);
                full_auto_done = 1'b1;
            end
            else if (!full_marked_done && jobs_sent - random_base >= 140) begin
                send_set(MAX_PROCS, shape, 1'b1);
                full_marked_done = 1'b1;
            end
            else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: jobs = $urandom_range(1, 6);
                    7, 8:                jobs = $urandom_range(7, 20);
                    default:             jobs = $urandom_range(21, 40);
                endcase
                send_set(jobs, shape, 1'b1);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Let the checker count the words of the final set before draining.
        repeat (2) @(posedge clk);
        // Wait for every predicted word, then give stray words time to show.
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: switch among stall patterns of random length, and twice hold
    // tready low for a long stretch so results back up and the input stalls.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int words;
        int hold_at;

        m_axis_tready <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        words     = 0;
        hold_at   = 40;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                words++;
            if (words >= hold_at && hold_at <= 200) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_at += 160;
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_OPEN, RX_SHUT);
                    mode_left = (mode == RX_SHUT) ? $urandom_range(1, 30)
                                                  : $urandom_range(20, 100);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    // Watchdog: abandon the run if no word moves for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/psw_pkg.sv
rtl/core/psw_store.sv
rtl/core/psw_div.sv
rtl/core/priority_schedule_wait_times_core.sv
rtl/core/psw_chk.sv
bench/priority_schedule_wait_times_check.sv
bench/priority_schedule_wait_times_core_test.sv
